// ----- hdl/cts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the CAN transport segmenter.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned CfgW      = 12;
  localparam int unsigned IdW       = 11;
  localparam int unsigned FrameLenW = 4;
  localparam int unsigned FrameW    = 64;
  localparam int unsigned BufW      = 56;
  localparam int unsigned FillW     = 3;
  localparam int unsigned SeqW      = 4;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 80;

  localparam logic [CfgW-1:0]      MaxLenReset = 12'd4095;
  localparam logic [3:0]           PciSingle   = 4'h0;
  localparam logic [3:0]           PciFirst    = 4'h1;
  localparam logic [3:0]           PciConsec   = 4'h2;
  localparam logic [FillW-1:0]     FfPayload   = 3'd6;
  localparam logic [FillW-1:0]     CfPayload   = 3'd7;
  localparam logic [FrameLenW-1:0] FfLen       = 4'd8;
  localparam logic                 StatusOk    = 1'b0;
  localparam logic                 StatusLong  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_CONSEC = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic [IdW-1:0]       frame_id;
    logic [FrameLenW-1:0] frame_len;
    logic [FrameW-1:0]    frame_data;
    logic                 last_frame;
    logic                 status;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/cts_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_framer
// Message state, payload buffering and ISO-TP frame assembly.
// ----------------------------------------------------------------------------
module cts_framer #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [cts_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire                          accept_i,
  input  wire  [7:0]                   msg_byte_i,
  input  wire  [cts_pkg::CfgW-1:0]     msg_length_i,
  input  wire  [cts_pkg::IdW-1:0]      can_id_i,
  output logic                         res_valid_o,
  output cts_pkg::result_t             res_o
);

  localparam int unsigned LenW = LENGTH_BITS;

  logic [cts_pkg::CfgW-1:0]  max_len_q;
  logic                      in_msg_q, in_msg_d;
  logic                      drop_q, drop_d;
  logic [LenW-1:0]           left_q, left_d;
  logic [LenW-1:0]           total_q, total_d;
  logic [cts_pkg::IdW-1:0]   held_id_q, held_id_d;
  cts_pkg::frame_kind_e      kind_q, kind_d;
  logic [cts_pkg::BufW-1:0]  buf_q, buf_d;
  logic [cts_pkg::FillW-1:0] fill_q, fill_d;
  logic [cts_pkg::SeqW-1:0]  seq_q, seq_d;

  logic [LenW-1:0]           len_m;
  logic                      too_long;
  logic [LenW-1:0]           e_total, e_left, n_left;
  logic [cts_pkg::IdW-1:0]   e_id;
  cts_pkg::frame_kind_e      e_kind;
  logic [cts_pkg::BufW-1:0]  e_buf, n_buf;
  logic [cts_pkg::FillW-1:0] e_fill, n_fill;
  logic [cts_pkg::SeqW-1:0]  e_seq;
  logic [cts_pkg::CfgW-1:0]  tot12;
  logic                      full, emit, last;

  always_comb begin
    len_m = msg_length_i[LenW-1:0];
    if (len_m == '0) begin
      len_m = LenW'(1);
    end
    too_long = cts_pkg::CfgW'(len_m) > max_len_q;

    e_id    = in_msg_q ? held_id_q : can_id_i;
    e_total = in_msg_q ? total_q   : len_m;
    e_left  = in_msg_q ? left_q    : len_m;
    e_buf   = in_msg_q ? buf_q     : '0;
    e_fill  = in_msg_q ? fill_q    : '0;
    e_seq   = in_msg_q ? seq_q     : '0;
    if (in_msg_q) begin
      e_kind = kind_q;
    end else if (len_m <= LenW'(7)) begin
      e_kind = cts_pkg::KIND_SINGLE;
    end else begin
      e_kind = cts_pkg::KIND_FIRST;
    end

    n_buf = e_buf;
    for (int i = 0; i < 7; i++) begin
      if (e_fill == 3'(i)) begin
        n_buf[8*i +: 8] = msg_byte_i;
      end
    end
    n_fill = e_fill + 3'd1;
    n_left = e_left - LenW'(1);
    tot12  = cts_pkg::CfgW'(e_total);
    last   = n_left == '0;

    case (e_kind)
      cts_pkg::KIND_SINGLE: full = LenW'(n_fill) >= e_total;
      cts_pkg::KIND_FIRST:  full = n_fill >= cts_pkg::FfPayload;
      default:              full = n_fill >= cts_pkg::CfPayload;
    endcase
    emit = full || last;
  end

  always_comb begin
    in_msg_d    = in_msg_q;
    drop_d      = drop_q;
    left_d      = left_q;
    total_d     = total_q;
    held_id_d   = held_id_q;
    kind_d      = kind_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    seq_d       = seq_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.frame_id = e_id;

    if (accept_i) begin
      if (!in_msg_q) begin
        held_id_d = can_id_i;
        total_d   = len_m;
        buf_d     = '0;
        fill_d    = '0;
        seq_d     = '0;
      end
      if (!in_msg_q && too_long) begin
        res_valid_o       = 1'b1;
        res_o.last_frame  = 1'b1;
        res_o.status      = cts_pkg::StatusLong;
        if (len_m > LenW'(1)) begin
          in_msg_d = 1'b1;
          drop_d   = 1'b1;
          left_d   = len_m - LenW'(1);
        end
      end else if (drop_q) begin
        left_d = left_q - LenW'(1);
        if (left_d == '0) begin
          in_msg_d = 1'b0;
          drop_d   = 1'b0;
        end
      end else begin
        in_msg_d = 1'b1;
        drop_d   = 1'b0;
        left_d   = n_left;
        kind_d   = e_kind;
        seq_d    = e_seq;
        buf_d    = n_buf;
        fill_d   = n_fill;
        if (emit) begin
          res_valid_o      = 1'b1;
          res_o.last_frame = last;
          res_o.status     = cts_pkg::StatusOk;
          case (e_kind)
            cts_pkg::KIND_SINGLE: begin
              res_o.frame_data = {n_buf, cts_pkg::PciSingle, tot12[3:0]};
              res_o.frame_len  = 4'd1 + 4'(n_fill);
            end
            cts_pkg::KIND_FIRST: begin
              res_o.frame_data = {n_buf[47:0], tot12[7:0], cts_pkg::PciFirst, tot12[11:8]};
              res_o.frame_len  = cts_pkg::FfLen;
              kind_d           = cts_pkg::KIND_CONSEC;
              seq_d            = 4'd1;
            end
            default: begin
              res_o.frame_data = {n_buf, cts_pkg::PciConsec, e_seq};
              res_o.frame_len  = 4'd1 + 4'(n_fill);
              seq_d            = e_seq + 4'd1;
            end
          endcase
          buf_d  = '0;
          fill_d = '0;
          if (last) begin
            in_msg_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= cts_pkg::MaxLenReset;
      in_msg_q  <= 1'b0;
      drop_q    <= 1'b0;
      left_q    <= '0;
      total_q   <= '0;
      held_id_q <= '0;
      kind_q    <= cts_pkg::KIND_SINGLE;
      buf_q     <= '0;
      fill_q    <= '0;
      seq_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      in_msg_q  <= in_msg_d;
      drop_q    <= drop_d;
      left_q    <= left_d;
      total_q   <= total_d;
      held_id_q <= held_id_d;
      kind_q    <= kind_d;
      buf_q     <= buf_d;
      fill_q    <= fill_d;
      seq_q     <= seq_d;
    end
  end

  a_drop_in_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> in_msg_q)
    else $error("dropping outside a message");

  a_left_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_msg_q |-> left_q != '0)
    else $error("open message with no bytes left");

  a_ff_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_msg_q && !drop_q && kind_q == cts_pkg::KIND_FIRST) |-> fill_q < cts_pkg::FfPayload)
    else $error("first frame buffer overfilled");

  a_fill_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_valid_o) |=> fill_q == '0)
    else $error("buffer not cleared after frame");

endmodule
`default_nettype wire

// ----- hdl/cts_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_out_reg
// Result holding register on the master side.
// ----------------------------------------------------------------------------
module cts_out_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire cts_pkg::result_t res_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  wire                  take_i,
  output cts_pkg::result_t     res_o
);

  logic             valid_q, valid_d;
  cts_pkg::result_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("result loaded over a pending transaction");

  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not presented");

  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.status == cts_pkg::StatusLong) |-> res_q.last_frame)
    else $error("error result without last flag");

endmodule
`default_nettype wire

// ----- hdl/can_transport_segmenter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_transport_segmenter_unit
// Segments a byte stream into ISO-TP single, first and consecutive frames.
// ----------------------------------------------------------------------------
// Slave side: one message byte per transaction; the length and identifier
// fields are sampled on the first byte of each message only.
// Master side: one transaction per CAN frame, tlast on the final frame of a
// message, tuser set on a too-long message (single error transaction, the
// remaining bytes of that message are consumed silently).
// cfg_we_i writes the maximum message length; write only while idle.
// Throughput: one byte per cycle. Latency: a frame leaves on the cycle after
// the byte that completes it, from a single result register.
// s_axis_tready is high while the result register is empty or being taken,
// so a stalled receiver holds off the input only once a frame is waiting.
// Reset clears the message state and the result valid flag and sets the
// maximum length to 4095.
// ----------------------------------------------------------------------------
module can_transport_segmenter_unit #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [cts_pkg::CfgW-1:0]         cfg_wdata_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] msg_byte, [19:8] msg_length, [30:20] can_id, [31] zero
  input  wire  [cts_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [10:0] frame_id, [14:11] frame_len, [78:15] frame_data, [79] zero
  output logic [cts_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast,
  // [0] status
  output logic                             m_axis_tuser
);

  logic             accept;
  logic             res_valid;
  cts_pkg::result_t res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  cts_framer #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .msg_byte_i   (s_axis_tdata[7:0]),
    .msg_length_i (s_axis_tdata[19:8]),
    .can_id_i     (s_axis_tdata[30:20]),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  cts_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.frame_data, out_res.frame_len, out_res.frame_id};
  assign m_axis_tlast = out_res.last_frame;
  assign m_axis_tuser = out_res.status;

endmodule
`default_nettype wire
